[hdl/shb_pkg.sv]
package shb_pkg;

   localparam logic [31:0] BUCKET_COUNT_RESET = 32'd1024;
   localparam logic [11:0] MAGIC_KEY = 12'd3559;
   localparam int unsigned SHIFT_AMOUNT = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic hash_update;
      logic fold_load;
      logic div_start;
      logic fold_update;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fold_done;
      logic div_done;
   } status_type;

endpackage

[hdl/shb_req_if.sv]
interface shb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[hdl/shb_rsp_if.sv]
interface shb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;
   logic [31:0] bucket_index;

   modport source (output valid, output hash_value, output bucket_index, input ready);
   modport sink (input valid, input hash_value, input bucket_index, output ready);
endinterface

[hdl/string_hash_to_bucket_unit.sv]
// String hash to bucket unit.
// The req_chan channel carries a string one byte per beat, with last_byte
// set on its final byte. Each byte updates a running hash (hash*17 plus the
// sign-extended byte xor 3559). On the last byte one beat leaves on rsp_chan
// with the hash and its bucket index, below the bucket count (zero when that
// count is below two) set through csr_wr_en/csr_wr_data. The count must be
// written only while the unit is idle; the unit itself does not enforce this.
// A byte that is not last keeps the unit idle, so the next byte is accepted in
// the following cycle. A last byte holds off the input while the hash is
// reduced by quotient-plus-remainder folds; each fold runs through the
// bit-serial divider, one quotient bit per cycle. With the output register
// free, the result beat is presented once the final check loads that register.
// The result sits in an output register; while it waits for rsp_chan.ready,
// further bytes of the next string are still accepted, and only the next
// result stalls until the register is free.
// Synchronous reset clears the running hash, empties the output register,
// and sets the bucket count to 1024.
module string_hash_to_bucket_unit #(
   parameter int unsigned HASH_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   shb_req_if.sink     req_chan,
   shb_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   shb_pkg::cmd_type    cmd;
   shb_pkg::status_type status;
   logic [31:0]         bucket_count;

   shb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_byte),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   shb_dpath #(
      .HASH_WIDTH (HASH_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .data_byte    (req_chan.data_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .bucket_count (bucket_count),
      .hash_value   (rsp_chan.hash_value),
      .bucket_index (rsp_chan.bucket_index)
   );

   // A last byte starts the fold, so no byte is taken in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.last_byte |=> !req_chan.ready)
      else $error("byte accepted right after a last byte");

   // A delivered index is always below a usable bucket count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (bucket_count >= 32'd2) |-> rsp_chan.bucket_index < bucket_count)
      else $error("bucket index not below bucket count");

   // With a bucket count of zero or one no fold is done.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (bucket_count < 32'd2) |-> rsp_chan.bucket_index == 32'd0)
      else $error("bucket index nonzero for degenerate bucket count");

   // The fold unit never starts a division once the value is already folded.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.fold_done)
      else $error("division started on a folded value");

endmodule

[hdl/shb_div.sv]
module shb_div #(
   parameter int unsigned HASH_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [HASH_WIDTH-1:0] dividend,
   input  logic [31:0]           divisor,
   output logic [HASH_WIDTH-1:0] quotient,
   output logic [31:0]           remainder,
   output logic                  done
);

   localparam int unsigned CNT_W = $clog2(HASH_WIDTH);

   logic [HASH_WIDTH-1:0] dq_ff, dq_in;
   logic [31:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [32:0]           rem_shift;
   logic [32:0]           diff;
   logic                  ge;

   // Restoring division: the dividend shifts out at the top of dq while
   // quotient bits shift in at the bottom, one bit per cycle.
   always_comb begin
      rem_shift = {rem_ff, dq_ff[HASH_WIDTH-1]};
      diff      = rem_shift - {1'b0, divisor};
      ge        = rem_shift >= {1'b0, divisor};
      dq_in     = dq_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         dq_in    = dividend;
         rem_in   = '0;
         count_in = CNT_W'(HASH_WIDTH - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         dq_in    = {dq_ff[HASH_WIDTH-2:0], ge};
         rem_in   = ge ? diff[31:0] : rem_shift[31:0];
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign quotient  = dq_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

[hdl/shb_dpath.sv]
module shb_dpath #(
   parameter int unsigned HASH_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  shb_pkg::cmd_type    cmd,
   output shb_pkg::status_type status,
   input  logic [7:0]          data_byte,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   output logic [31:0]         bucket_count,
   output logic [31:0]         hash_value,
   output logic [31:0]         bucket_index
);

   logic [HASH_WIDTH-1:0] running_hash_ff, running_hash_in;
   logic [HASH_WIDTH-1:0] fold_val_ff, fold_val_in;
   logic [HASH_WIDTH-1:0] term;
   logic [HASH_WIDTH-1:0] new_hash;
   logic [HASH_WIDTH-1:0] quotient;
   logic [31:0]           remainder;
   logic                  div_done;
   logic [31:0]           bucket_count_ff;
   logic [31:0]           saved_hash_ff;
   logic [31:0]           rsp_hash_ff;
   logic [31:0]           rsp_index_ff;
   logic                  count_small;

   // The byte is read as a signed char, so it is sign-extended before the xor.
   assign term = {{(HASH_WIDTH-8){data_byte[7]}}, data_byte}
                 ^ HASH_WIDTH'(shb_pkg::MAGIC_KEY);
   assign new_hash = running_hash_ff + (running_hash_ff << shb_pkg::SHIFT_AMOUNT) + term;

   assign count_small = bucket_count_ff < 32'd2;

   always_comb begin
      running_hash_in = running_hash_ff;
      fold_val_in     = fold_val_ff;
      if (cmd.hash_update) begin
         running_hash_in = cmd.fold_load ? '0 : new_hash;
      end
      if (cmd.fold_load) begin
         fold_val_in = new_hash;
      end else if (cmd.fold_update) begin
         fold_val_in = quotient + HASH_WIDTH'(remainder);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= '0;
         bucket_count_ff <= shb_pkg::BUCKET_COUNT_RESET;
      end else begin
         running_hash_ff <= running_hash_in;
         if (csr_wr_en) begin
            bucket_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      fold_val_ff <= fold_val_in;
      if (cmd.fold_load) begin
         saved_hash_ff <= new_hash[31:0];
      end
      if (cmd.out_load) begin
         rsp_hash_ff  <= saved_hash_ff;
         rsp_index_ff <= count_small ? 32'd0 : fold_val_ff[31:0];
      end
   end

   shb_div #(
      .HASH_WIDTH (HASH_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (fold_val_ff),
      .divisor   (bucket_count_ff),
      .quotient  (quotient),
      .remainder (remainder),
      .done      (div_done)
   );

   assign status.fold_done = count_small || (fold_val_ff < HASH_WIDTH'(bucket_count_ff));
   assign status.div_done  = div_done;
   assign bucket_count     = bucket_count_ff;
   assign hash_value       = rsp_hash_ff;
   assign bucket_index     = rsp_index_ff;

endmodule

[hdl/shb_ctrl.sv]
module shb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output shb_pkg::cmd_type    cmd,
   input  shb_pkg::status_type status
);

   shb_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         shb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.hash_update = 1'b1;
               if (req_last) begin
                  cmd.fold_load = 1'b1;
                  state_in      = shb_pkg::ST_CHECK;
               end
            end
         end
         shb_pkg::ST_CHECK: begin
            if (status.fold_done) begin
               // The result waits here until the output register is free.
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.out_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = shb_pkg::ST_IDLE;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = shb_pkg::ST_DIV;
            end
         end
         shb_pkg::ST_DIV: begin
            if (status.div_done) begin
               cmd.fold_update = 1'b1;
               state_in        = shb_pkg::ST_CHECK;
            end
         end
         default: begin
            state_in = shb_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
